// ===== rtl/core/spibr_pkg.sv =====
// ----------------------------------------------------------------------------
// spibr_pkg: shared types and constants of the SPI bridge command parser
// Word layouts, one-hot parse modes and command codes.
// ----------------------------------------------------------------------------
package spibr_pkg;

    typedef struct packed {
        logic [7:0] host_byte;
        logic [7:0] miso_byte;
    } in_word_t;

    typedef struct packed {
        logic        spi_valid;
        logic [7:0]  spi_byte;
        logic        reply_valid;
        logic [7:0]  reply_byte;
        logic        cs_level;
        logic        pin_a_level;
        logic        pin_b_level;
        logic        pins_attached;
        logic [15:0] crc_value;
    } out_word_t;

    typedef enum logic [5:0] {
        MODE_IDLE   = 6'b000001,
        MODE_DUPLEX = 6'b000010,
        MODE_WRONLY = 6'b000100,
        MODE_ARG_A  = 6'b001000,
        MODE_ARG_B  = 6'b010000,
        MODE_ARG_E  = 6'b100000
    } mode_t;

    typedef struct packed {
        logic enable;
        logic duplex;
    } crc_ctrl_t;

    localparam int unsigned BURST_BIT  = 7;
    localparam int unsigned WRONLY_BIT = 6;
    localparam logic [7:0] BURST_LEN_MASK = 8'h3F;
    localparam int unsigned COUNT_W = 7;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] CMD_SELECT   = 8'h73; // 's'
    localparam logic [7:0] CMD_UNSELECT = 8'h75; // 'u'
    localparam logic [7:0] CMD_PIN_A    = 8'h61; // 'a'
    localparam logic [7:0] CMD_PIN_B    = 8'h62; // 'b'
    localparam logic [7:0] CMD_ECHO     = 8'h65; // 'e'
    localparam logic [7:0] CMD_DETACH   = 8'h78; // 'x'

endpackage

// ===== rtl/core/spibr_if.sv =====
// ----------------------------------------------------------------------------
// spibr_in_if / spibr_out_if: valid-ready channels of the bridge parser
// A word moves at a rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface spibr_in_if;
    logic               valid;
    logic               ready;
    spibr_pkg::in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface spibr_out_if;
    logic                valid;
    logic                ready;
    spibr_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/spibr_crc.sv =====
// ----------------------------------------------------------------------------
// spibr_crc: CRC-16/XMODEM update for one step
// Folds the MOSI byte, then the MISO byte on duplex steps, into the CRC.
// ----------------------------------------------------------------------------
module spibr_crc
(
    input  spibr_pkg::crc_ctrl_t ctrl,
    input  logic [15:0]          crc_in,
    input  logic [7:0]           mosi_byte,
    input  logic [7:0]           miso_byte,
    output logic [15:0]          crc_out
);

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] v;
        v = c ^ {d, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (v[15])
            begin
                v = {v[14:0], 1'b0} ^ spibr_pkg::CRC_POLY;
            end
            else
            begin
                v = {v[14:0], 1'b0};
            end
        end
        return v;
    endfunction

    logic [15:0] crc_mosi;

    always_comb
    begin
        crc_mosi = crc_byte(crc_in, mosi_byte);
        if (!ctrl.enable)
        begin
            crc_out = crc_in;
        end
        else if (ctrl.duplex)
        begin
            crc_out = crc_byte(crc_mosi, miso_byte);
        end
        else
        begin
            crc_out = crc_mosi;
        end
    end

endmodule

// ===== rtl/core/spibr_parser.sv =====
// ----------------------------------------------------------------------------
// spibr_parser: command decoder and pin state of the bridge
// Holds mode, burst count, CRC and pin levels; builds the result word.
// ----------------------------------------------------------------------------
module spibr_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  spibr_pkg::in_word_t  item,
    output spibr_pkg::out_word_t result
);

    spibr_pkg::mode_t                    mode_reg, mode_next;
    logic [spibr_pkg::COUNT_W-1:0]       left_reg, left_next;
    logic [spibr_pkg::COUNT_W-1:0]       left_dec;
    logic [15:0]                         crc_reg, crc_next;
    logic                                cs_reg, cs_next;
    logic                                a_reg, a_next;
    logic                                b_reg, b_next;
    logic                                att_reg, att_next;
    spibr_pkg::crc_ctrl_t                crc_ctrl;
    logic [7:0]                          hb;

    assign hb = item.host_byte;

    spibr_crc u_crc
    (
        .ctrl      (crc_ctrl),
        .crc_in    (crc_reg),
        .mosi_byte (hb),
        .miso_byte (item.miso_byte),
        .crc_out   (crc_next)
    );

    always_comb
    begin
        mode_next       = spibr_pkg::MODE_IDLE;
        left_next       = left_reg;
        left_dec        = left_reg;
        cs_next         = cs_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        att_next        = att_reg;
        crc_ctrl.enable = 1'b0;
        crc_ctrl.duplex = 1'b0;
        result          = '0;

        unique case (mode_reg)
            spibr_pkg::MODE_DUPLEX, spibr_pkg::MODE_WRONLY:
            begin
                result.spi_valid = 1'b1;
                result.spi_byte  = hb;
                crc_ctrl.enable  = 1'b1;
                if (mode_reg == spibr_pkg::MODE_DUPLEX)
                begin
                    crc_ctrl.duplex    = 1'b1;
                    result.reply_valid = 1'b1;
                    result.reply_byte  = item.miso_byte;
                end
                if (left_reg != '0)
                begin
                    left_dec = left_reg - 1'b1;
                end
                left_next = left_dec;
                mode_next = (left_dec == '0) ? spibr_pkg::MODE_IDLE : mode_reg;
            end
            spibr_pkg::MODE_ARG_A:
            begin
                att_next = 1'b1;
                a_next   = hb[0];
            end
            spibr_pkg::MODE_ARG_B:
            begin
                att_next = 1'b1;
                b_next   = hb[0];
            end
            spibr_pkg::MODE_ARG_E:
            begin
                result.reply_valid = 1'b1;
                result.reply_byte  = hb;
            end
            default:
            begin
                if (hb[spibr_pkg::BURST_BIT])
                begin
                    att_next  = 1'b1;
                    left_next = spibr_pkg::COUNT_W'(hb & spibr_pkg::BURST_LEN_MASK) + 1'b1;
                    mode_next = hb[spibr_pkg::WRONLY_BIT] ? spibr_pkg::MODE_WRONLY
                                                           : spibr_pkg::MODE_DUPLEX;
                end
                else if (hb == spibr_pkg::CMD_SELECT)
                begin
                    att_next = 1'b1;
                    cs_next  = 1'b0;
                end
                else if (hb == spibr_pkg::CMD_UNSELECT)
                begin
                    att_next = 1'b1;
                    cs_next  = 1'b1;
                end
                else if (hb == spibr_pkg::CMD_PIN_A)
                begin
                    mode_next = spibr_pkg::MODE_ARG_A;
                end
                else if (hb == spibr_pkg::CMD_PIN_B)
                begin
                    mode_next = spibr_pkg::MODE_ARG_B;
                end
                else if (hb == spibr_pkg::CMD_ECHO)
                begin
                    mode_next = spibr_pkg::MODE_ARG_E;
                end
                else if (hb == spibr_pkg::CMD_DETACH)
                begin
                    att_next = 1'b0;
                end
            end
        endcase

        result.cs_level      = cs_next;
        result.pin_a_level   = a_next;
        result.pin_b_level   = b_next;
        result.pins_attached = att_next;
        result.crc_value     = crc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= spibr_pkg::MODE_IDLE;
            left_reg <= '0;
            crc_reg  <= '0;
            cs_reg   <= 1'b1;
            a_reg    <= 1'b0;
            b_reg    <= 1'b0;
            att_reg  <= 1'b1;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            left_reg <= left_next;
            crc_reg  <= crc_next;
            cs_reg   <= cs_next;
            a_reg    <= a_next;
            b_reg    <= b_next;
            att_reg  <= att_next;
        end
    end

endmodule

// ===== rtl/core/spi_bridge_command_parser.sv =====
// ----------------------------------------------------------------------------
// spi_bridge_command_parser: host-to-SPI bridge command parser
// Path: an accepted input word waits in the input register; its result word
// is registered in the result register and held there until rsp takes it.
// Throughput: one word per cycle while rsp.ready stays high; a waiting result
// stalls intake once the input register also holds a word.
// Reset: rst_n empties both registers, idles the parser, zeroes the CRC,
// deasserts chip select, clears pins A and B and attaches the pins.
// ----------------------------------------------------------------------------
module spi_bridge_command_parser
(
    input  logic          clk,
    input  logic          rst_n,
    spibr_in_if.sink      cmd,
    spibr_out_if.source   rsp
);

    logic                 in_vld_reg;
    spibr_pkg::in_word_t  in_data_reg;
    logic                 out_vld_reg;
    spibr_pkg::out_word_t out_data_reg;
    spibr_pkg::out_word_t result;
    logic                 step;

    // advance when a word is held and the result register frees up
    assign step      = in_vld_reg && (!out_vld_reg || rsp.ready);
    assign cmd.ready = !in_vld_reg || step;
    assign rsp.valid = out_vld_reg;
    assign rsp.data  = out_data_reg;

    spibr_parser u_parser
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_data_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
            begin
                in_vld_reg <= cmd.valid;
            end
            if (step)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            in_data_reg <= cmd.data;
        end
        if (step)
        begin
            out_data_reg <= result;
        end
    end

endmodule
